### rtl/slr_pkg.sv
`timescale 1ns / 1ps

package slr_pkg;

    // Default sizing of the ring
    localparam int LINES_MAX_DEF = 256;
    localparam int COLS_MAX_DEF  = 128;
    localparam int CELL_BITS_DEF = 32;

    // Fixed field widths of the ports
    localparam int FUNC_W     = 2;
    localparam int COLUMN_W   = 7;
    localparam int CELL_W     = 32;
    localparam int DELTA_W    = 10;
    localparam int ROW_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Register values after reset, before clamping
    localparam int LINE_COLUMNS_RST  = 80;
    localparam int HISTORY_LINES_RST = 256;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CAPTURE    = 2'd0,
        FUNC_SCROLL     = 2'd1,
        FUNC_VIEW_RESET = 2'd2,
        FUNC_READ       = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_COLUMNS  = 1'b0,
        CFG_HISTORY_LINES = 1'b1
    } cfg_index_t;

    // Index width for n entries, at least one bit
    function automatic int index_bits(input int n);
        int w;
        begin
            w = (n > 1) ? $clog2(n) : 1;
            return w;
        end
    endfunction

endpackage

### rtl/slr_store.sv
`timescale 1ns / 1ps

module slr_store #(
    parameter int LINES_MAX = slr_pkg::LINES_MAX_DEF,
    parameter int COLS_MAX  = slr_pkg::COLS_MAX_DEF,
    parameter int CELL_BITS = slr_pkg::CELL_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear_start,
    output logic                 clearing,
    input  logic                 wr_req,
    input  logic [slr_pkg::index_bits(LINES_MAX)+slr_pkg::index_bits(COLS_MAX)-1:0] wr_addr,
    input  logic [CELL_BITS-1:0] wr_cell,
    input  logic [slr_pkg::index_bits(LINES_MAX)+slr_pkg::index_bits(COLS_MAX)-1:0] rd_addr,
    output logic [CELL_BITS-1:0] rd_cell
);
    import slr_pkg::*;

    localparam int ADDR_W = index_bits(LINES_MAX) + index_bits(COLS_MAX);
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [CELL_BITS-1:0] mem [DEPTH];
    logic [CELL_BITS-1:0] rd_cell_reg;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    clr_addr_next;
    logic                 port_we;
    logic [ADDR_W-1:0]    port_addr;
    logic [CELL_BITS-1:0] port_data;

    // Sweep the whole array once after reset and after each register write
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_start)
        begin
            clearing_next = 1'b1;
            clr_addr_next = '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Share the single write port between the sweep and captured words
    always_comb
    begin
        port_we   = wr_req;
        port_addr = wr_addr;
        port_data = wr_cell;
        if (clearing_reg)
        begin
            port_we   = 1'b1;
            port_addr = clr_addr_reg;
            port_data = '0;
        end
    end

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (port_we)
        begin
            mem[port_addr] <= port_data;
        end
        rd_cell_reg <= mem[rd_addr];
    end

    assign clearing = clearing_reg;
    assign rd_cell  = rd_cell_reg;

endmodule

### rtl/slr_ctrl.sv
`timescale 1ns / 1ps

module slr_ctrl #(
    parameter int LINES_MAX = slr_pkg::LINES_MAX_DEF,
    parameter int COLS_MAX  = slr_pkg::COLS_MAX_DEF,
    parameter int CELL_BITS = slr_pkg::CELL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_clear,
    input  logic [$clog2(COLS_MAX+1)-1:0]        line_cols,
    input  logic [$clog2(LINES_MAX+1)-1:0]       hist_lines,
    input  logic                                 item_valid,
    input  slr_pkg::func_t                       item_func,
    input  logic [slr_pkg::COLUMN_W-1:0]         item_column,
    input  logic [CELL_BITS-1:0]                 item_cell,
    input  logic                                 item_last,
    input  logic signed [slr_pkg::DELTA_W-1:0]   item_delta,
    input  logic [slr_pkg::ROW_W-1:0]            item_row,
    output logic                                 wr_req,
    output logic [slr_pkg::index_bits(LINES_MAX)+slr_pkg::index_bits(COLS_MAX)-1:0] wr_addr,
    output logic [CELL_BITS-1:0]                 wr_cell,
    output logic [slr_pkg::index_bits(LINES_MAX)+slr_pkg::index_bits(COLS_MAX)-1:0] rd_addr,
    output logic                                 res_valid,
    output logic                                 res_ok,
    output logic                                 res_hit,
    output logic [$clog2(LINES_MAX+1)-1:0]       count,
    output logic [$clog2(LINES_MAX+1)-1:0]       offset
);
    import slr_pkg::*;

    localparam int LINE_W = index_bits(LINES_MAX);
    localparam int COL_W  = index_bits(COLS_MAX);
    localparam int CNT_W  = $clog2(LINES_MAX + 1);
    localparam int COL_CW = $clog2(COLS_MAX + 1);
    localparam int CMP_W  = ((COLUMN_W > COL_CW) ? COLUMN_W : COL_CW);
    localparam int SUM_W  = ((CNT_W > DELTA_W) ? CNT_W : DELTA_W) + 2;
    localparam int RW     = ((ROW_W > CNT_W) ? ROW_W : CNT_W) + 1;
    localparam int IW     = RW + 2;

    logic [LINE_W-1:0]       head_reg;
    logic [LINE_W-1:0]       head_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        offset_reg;
    logic [CNT_W-1:0]        offset_next;
    logic                    res_valid_reg;
    logic                    res_ok_reg;
    logic                    res_ok_next;
    logic                    res_hit_reg;
    logic                    res_hit_next;

    logic                    col_ok;
    logic [COL_W-1:0]        col_addr;
    logic signed [SUM_W-1:0] scroll_sum;
    logic [RW-1:0]           back;
    logic signed [IW-1:0]    ring_pos;
    logic signed [IW-1:0]    ring_idx;

    // Decode column and ring position for the current word
    always_comb
    begin
        col_ok     = CMP_W'(item_column) < CMP_W'(line_cols);
        col_addr   = COL_W'(item_column);
        scroll_sum = $signed(SUM_W'(offset_reg)) + SUM_W'(item_delta);
        back       = RW'(offset_reg) - RW'(item_row) - RW'(1);
        ring_pos   = $signed(IW'(head_reg)) + $signed(IW'(item_row))
                     - $signed(IW'(offset_reg));
        ring_idx   = ring_pos;
        if (ring_pos < 0)
        begin
            ring_idx = ring_pos + $signed(IW'(hist_lines));
        end
    end

    // Apply one command to head, count and view offset
    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        res_ok_next  = 1'b0;
        res_hit_next = 1'b0;
        wr_req       = 1'b0;
        if (item_valid)
        begin
            unique case (item_func)
                FUNC_CAPTURE:
                begin
                    wr_req = col_ok;
                    if (item_last)
                    begin
                        if (CNT_W'(head_reg) + CNT_W'(1) == hist_lines)
                        begin
                            head_next = '0;
                        end
                        else
                        begin
                            head_next = head_reg + LINE_W'(1);
                        end
                        if (count_reg < hist_lines)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        // keep a scrolled view on the same text
                        if ((offset_reg != '0) && (offset_reg < count_next))
                        begin
                            offset_next = offset_reg + CNT_W'(1);
                        end
                    end
                end
                FUNC_SCROLL:
                begin
                    if (scroll_sum[SUM_W-1])
                    begin
                        offset_next = '0;
                    end
                    else if (scroll_sum > $signed(SUM_W'(count_reg)))
                    begin
                        offset_next = count_reg;
                    end
                    else
                    begin
                        offset_next = CNT_W'(scroll_sum);
                    end
                    res_ok_next = (offset_next != offset_reg);
                end
                FUNC_VIEW_RESET:
                begin
                    res_ok_next = (offset_reg != '0);
                    offset_next = '0;
                end
                FUNC_READ:
                begin
                    if ((RW'(item_row) < RW'(offset_reg)) && col_ok
                        && (back < RW'(count_reg)))
                    begin
                        res_ok_next  = 1'b1;
                        res_hit_next = 1'b1;
                    end
                end
                default:
                begin
                    res_ok_next = 1'b0;
                end
            endcase
        end
    end

    assign wr_addr = {head_reg, col_addr};
    assign wr_cell = item_cell;
    assign rd_addr = {LINE_W'(ring_idx), col_addr};

    // Hold ring state; drop it on a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (cfg_clear)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            res_valid_reg <= item_valid;
        end
    end

    // Result flags travel with the memory read
    always_ff @(posedge clk)
    begin
        res_ok_reg  <= res_ok_next;
        res_hit_reg <= res_hit_next;
    end

    assign res_valid = res_valid_reg;
    assign res_ok    = res_ok_reg;
    assign res_hit   = res_hit_reg;
    assign count     = count_reg;
    assign offset    = offset_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hist_lines)
        else $error("line count above ring depth");

    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= count_reg)
        else $error("view offset beyond stored lines");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(head_reg) < hist_lines)
        else $error("head outside the ring");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_clear |=> (count_reg == '0) && (offset_reg == '0) && (head_reg == '0))
        else $error("ring state not cleared on register write");
`endif

endmodule

### rtl/scrollback_line_ring.sv
`timescale 1ns / 1ps

// Terminal scrollback store. One command word is taken per clock while busy
// is low; its result passes the command and result registers and shows on
// the result ports for exactly one cycle, marked by done, and must be taken
// then. Commands may be issued back to back at one per cycle, limited by the
// single read and single write port of the history array. After reset and
// after every register write busy stays high while all LINES_MAX x COLS_MAX
// words (rounded up to powers of two; 32768 by default) are swept to zero.
// Register writes clear the history and return the view to live.
module scrollback_line_ring #(
    parameter int LINES_MAX = slr_pkg::LINES_MAX_DEF,
    parameter int COLS_MAX  = slr_pkg::COLS_MAX_DEF,
    parameter int CELL_BITS = slr_pkg::CELL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [slr_pkg::FUNC_W-1:0]          func,
    input  logic [slr_pkg::COLUMN_W-1:0]        column,
    input  logic [slr_pkg::CELL_W-1:0]          cell_in,
    input  logic                                last_cell,
    input  logic signed [slr_pkg::DELTA_W-1:0]  scroll_delta,
    input  logic [slr_pkg::ROW_W-1:0]           screen_row,
    output logic                                done,
    output logic                                ok,
    output logic [slr_pkg::CELL_W-1:0]          cell_out,
    output logic [slr_pkg::COUNT_W-1:0]         stored_count,
    output logic [slr_pkg::COUNT_W-1:0]         view_offset,
    input  logic                                wr_en,
    input  logic [slr_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]      wr_data
);
    import slr_pkg::*;

    localparam int ADDR_W   = index_bits(LINES_MAX) + index_bits(COLS_MAX);
    localparam int CNT_W    = $clog2(LINES_MAX + 1);
    localparam int COL_CW   = $clog2(COLS_MAX + 1);
    localparam int COLS_RST = (LINE_COLUMNS_RST > COLS_MAX) ? COLS_MAX : LINE_COLUMNS_RST;
    localparam int HIST_RST = (HISTORY_LINES_RST > LINES_MAX) ? LINES_MAX
                                                              : HISTORY_LINES_RST;

    logic [COL_CW-1:0]          line_cols_reg;
    logic [COL_CW-1:0]          line_cols_next;
    logic [CNT_W-1:0]           hist_lines_reg;
    logic [CNT_W-1:0]           hist_lines_next;

    logic                       item_valid_reg;
    func_t                      item_func_reg;
    logic [COLUMN_W-1:0]        item_column_reg;
    logic [CELL_BITS-1:0]       item_cell_reg;
    logic                       item_last_reg;
    logic signed [DELTA_W-1:0]  item_delta_reg;
    logic [ROW_W-1:0]           item_row_reg;

    logic                       accept;
    logic                       clearing;
    logic                       wr_req;
    logic [ADDR_W-1:0]          wr_addr;
    logic [CELL_BITS-1:0]       wr_cell;
    logic [ADDR_W-1:0]          rd_addr;
    logic [CELL_BITS-1:0]       rd_cell;
    logic                       res_valid;
    logic                       res_ok;
    logic                       res_hit;
    logic [CNT_W-1:0]           count;
    logic [CNT_W-1:0]           offset;

    assign busy   = clearing;
    assign accept = start && !clearing;

    // Clamp register values to the usable range
    always_comb
    begin
        if (wr_data[7:0] == '0)
        begin
            line_cols_next = COL_CW'(1);
        end
        else if (32'(wr_data[7:0]) > COLS_MAX)
        begin
            line_cols_next = COL_CW'(COLS_MAX);
        end
        else
        begin
            line_cols_next = COL_CW'(wr_data[7:0]);
        end
        if (wr_data == '0)
        begin
            hist_lines_next = CNT_W'(1);
        end
        else if (32'(wr_data) > LINES_MAX)
        begin
            hist_lines_next = CNT_W'(LINES_MAX);
        end
        else
        begin
            hist_lines_next = CNT_W'(wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cols_reg  <= COL_CW'(COLS_RST);
            hist_lines_reg <= CNT_W'(HIST_RST);
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_LINE_COLUMNS:  line_cols_reg  <= line_cols_next;
                CFG_HISTORY_LINES: hist_lines_reg <= hist_lines_next;
                default:           line_cols_reg  <= line_cols_reg;
            endcase
        end
    end

    // Register the incoming command word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_func_reg   <= func_t'(func);
            item_column_reg <= column;
            item_cell_reg   <= CELL_BITS'(cell_in);
            item_last_reg   <= last_cell;
            item_delta_reg  <= scroll_delta;
            item_row_reg    <= screen_row;
        end
    end

    slr_ctrl #(
        .LINES_MAX (LINES_MAX),
        .COLS_MAX  (COLS_MAX),
        .CELL_BITS (CELL_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_clear   (wr_en),
        .line_cols   (line_cols_reg),
        .hist_lines  (hist_lines_reg),
        .item_valid  (item_valid_reg),
        .item_func   (item_func_reg),
        .item_column (item_column_reg),
        .item_cell   (item_cell_reg),
        .item_last   (item_last_reg),
        .item_delta  (item_delta_reg),
        .item_row    (item_row_reg),
        .wr_req      (wr_req),
        .wr_addr     (wr_addr),
        .wr_cell     (wr_cell),
        .rd_addr     (rd_addr),
        .res_valid   (res_valid),
        .res_ok      (res_ok),
        .res_hit     (res_hit),
        .count       (count),
        .offset      (offset)
    );

    slr_store #(
        .LINES_MAX (LINES_MAX),
        .COLS_MAX  (COLS_MAX),
        .CELL_BITS (CELL_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (wr_en),
        .clearing    (clearing),
        .wr_req      (wr_req),
        .wr_addr     (wr_addr),
        .wr_cell     (wr_cell),
        .rd_addr     (rd_addr),
        .rd_cell     (rd_cell)
    );

    // Present the result word
    assign done         = res_valid;
    assign ok           = res_ok;
    assign cell_out     = res_hit ? CELL_W'(rd_cell) : '0;
    assign stored_count = COUNT_W'(count);
    assign view_offset  = COUNT_W'(offset);

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !wr_en |=> ##1 done)
        else $error("result word missing two cycles after command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result word without a command");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> cell_out == '0)
        else $error("cell data on a miss");
`endif

endmodule
